// ===== hdl/bpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded priority queue package
// Sizes, status and operation codes, and the item and store port types.
// ----------------------------------------------------------------------------
`default_nettype none

package bpq_pkg;

  localparam int CAPACITY   = 1024;
  localparam int MAX_REMOVE = 64;

  localparam int ADDR_W  = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int COUNT_W = 7;
  localparam int CMP_W   = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_DELETE = 1'b1;

  localparam logic [1:0] STAT_INSERTED = 2'd0;
  localparam logic [1:0] STAT_FULL     = 2'd1;
  localparam logic [1:0] STAT_REMOVED  = 2'd2;
  localparam logic [1:0] STAT_EMPTY    = 2'd3;

  typedef struct packed {
    logic                op;
    logic signed [31:0]  entry_key;
    logic signed [31:0]  entry_value;
    logic [COUNT_W-1:0]  count;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_key;
    logic signed [31:0] out_value;
    logic [1:0]         status;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] key;
    logic signed [31:0] value;
  } entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    entry_t            wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== hdl/bounded_priority_queue.sv =====
// ----------------------------------------------------------------------------
// Bounded priority queue
// Holds up to CAPACITY signed key and value pairs in insertion order. An
// insert command stores one entry and returns one status result. A delete
// command removes up to count entries (one for count 0, MAX_REMOVE at most),
// largest key first (earliest entry on equal keys), and returns one result
// per entry with last set on the final one; a delete from an empty queue
// returns a single empty status. Both channels transfer when valid is high
// and stall is low. Commands are taken only while the sequencer is idle; a
// finished result waits in the output register while the next command is
// already accepted. Each removal makes two passes over the stored entries:
// one pass through the memory read port compares every key in the shared
// comparator, a second pass moves the tail down by one entry. A receiver
// stall holds the output register and pauses the sequencer at its next
// result. Reset empties the queue; the memory needs no clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_priority_queue import bpq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  in_item_t  cmd,
  output logic      res_valid,
  input  logic      res_stall,
  output out_item_t res
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_SHIFT = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]         state;
  logic [1:0]         after;
  logic [CNT_W-1:0]   entry_count;
  logic [CNT_W-1:0]   rd_idx;
  logic               dv;
  logic [ADDR_W-1:0]  da;
  logic               first;
  entry_t             best;
  logic [ADDR_W-1:0]  best_idx;
  logic [COUNT_W-1:0] remaining;
  out_item_t          pending;
  mem_req_t           mreq;
  entry_t             rdata;
  logic               cmd_acc;
  logic               issue;
  logic               load_out;
  logic               full;
  logic [COUNT_W-1:0] want;

  bpq_store u_store (
    .clk   (clk),
    .req   (mreq),
    .rdata (rdata)
  );

  assign cmd_stall = rst || (state != S_IDLE);
  assign cmd_acc   = cmd_valid && !cmd_stall;
  assign full      = (entry_count == CNT_W'(CAPACITY));
  assign issue     = ((state == S_SCAN) || (state == S_SHIFT)) && (rd_idx < entry_count);
  assign load_out  = !res_valid || !res_stall;

  always_comb begin
    if (cmd.count == '0) begin
      want = COUNT_W'(1);
    end else if (cmd.count > COUNT_W'(MAX_REMOVE)) begin
      want = COUNT_W'(MAX_REMOVE);
    end else begin
      want = cmd.count;
    end
    if (CMP_W'(want) > CMP_W'(entry_count)) begin
      want = COUNT_W'(entry_count);
    end
  end

  always_comb begin
    mreq.we    = 1'b0;
    mreq.waddr = da - ADDR_W'(1);
    mreq.wdata = rdata;
    mreq.raddr = rd_idx[ADDR_W-1:0];
    if ((state == S_IDLE) && cmd_acc && (cmd.op == OP_INSERT) && !full) begin
      mreq.we          = 1'b1;
      mreq.waddr       = entry_count[ADDR_W-1:0];
      mreq.wdata.key   = cmd.entry_key;
      mreq.wdata.value = cmd.entry_value;
    end else if ((state == S_SHIFT) && dv) begin
      mreq.we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      res_valid   <= 1'b0;
      dv          <= 1'b0;
    end else begin
      dv <= issue;
      da <= rd_idx[ADDR_W-1:0];
      if ((state == S_EMIT) && load_out) begin
        res_valid <= 1'b1;
        res       <= pending;
      end else if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            after <= S_IDLE;
            if (cmd.op == OP_INSERT) begin
              state <= S_EMIT;
              if (full) begin
                pending <= '{out_key: '0, out_value: '0, status: STAT_FULL, last: 1'b1};
              end else begin
                entry_count <= entry_count + CNT_W'(1);
                pending <= '{out_key: '0, out_value: '0, status: STAT_INSERTED, last: 1'b1};
              end
            end else if (entry_count == '0) begin
              state   <= S_EMIT;
              pending <= '{out_key: '0, out_value: '0, status: STAT_EMPTY, last: 1'b1};
            end else begin
              remaining <= want;
              rd_idx    <= '0;
              first     <= 1'b1;
              state     <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (issue) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          if (dv) begin
            if (first || ($signed(rdata.key) > $signed(best.key))) begin
              best     <= rdata;
              best_idx <= da;
            end
            first <= 1'b0;
          end
          if (!issue && !dv) begin
            rd_idx <= CNT_W'(best_idx) + CNT_W'(1);
            state  <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          if (issue) begin
            rd_idx <= rd_idx + CNT_W'(1);
          end
          if (!issue && !dv) begin
            entry_count       <= entry_count - CNT_W'(1);
            pending.out_key   <= best.key;
            pending.out_value <= best.value;
            pending.status    <= STAT_REMOVED;
            pending.last      <= (remaining == COUNT_W'(1));
            remaining         <= remaining - COUNT_W'(1);
            after             <= (remaining == COUNT_W'(1)) ? S_IDLE : S_SCAN;
            rd_idx            <= '0;
            first             <= 1'b1;
            state             <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (load_out) begin
            state <= after;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_busy_nonempty: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SCAN) || (state == S_SHIFT)) |-> (entry_count != '0) && (remaining != '0))
    else $error("removal running on an empty queue");

  a_idle_write: assert property (@(posedge clk) disable iff (rst)
    (mreq.we && (state == S_IDLE)) |-> (cmd_acc && (cmd.op == OP_INSERT) && !full))
    else $error("store written in idle without an accepted insert");

  a_remove_dec: assert property (@(posedge clk) disable iff (rst)
    ((state == S_SHIFT) && !issue && !dv) |=>
      (entry_count == $past(entry_count) - CNT_W'(1)))
    else $error("entry count not decremented after a removal");

endmodule

`default_nettype wire

// ===== hdl/bpq_store.sv =====
// ----------------------------------------------------------------------------
// Bounded priority queue entry store
// Key and value memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bpq_store import bpq_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rdata
);

  entry_t mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rdata <= mem[req.raddr];
  end

endmodule

`default_nettype wire
